>>> design/rect_occupancy_bitmap_top_assert.svh
// Assertion macros for the rectangle occupancy bitmap checker.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef RECT_OCCUPANCY_BITMAP_TOP_ASSERT_SVH
`define RECT_OCCUPANCY_BITMAP_TOP_ASSERT_SVH

// Next-cycle implication, off while reset is low.
`define ROC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define ROC_ASSERT_NEXT_ANY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/roc_pkg.sv
// Shared types and constants for the rectangle occupancy bitmap.
// No dependencies; used by roc_in_if, the top, the controller and the datapath.
package roc_pkg;

  localparam int OP_W  = 2;
  localparam int POS_W = 9;
  localparam int EXT_W = 10;
  localparam int SUM_W = 11;

  localparam int DEF_GRID_ROWS = 64;
  localparam int DEF_GRID_COLS = 64;
  localparam int DEF_CELL_SIZE = 8;

  // Reciprocal divide: exact for sums below 2**SUM_W and cell sizes up to 64
  localparam int DIV_SH  = 18;
  localparam int RECIP_W = 19;

  localparam logic [OP_W-1:0] OP_TEST  = 2'd0;
  localparam logic [OP_W-1:0] OP_MARK  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic load;
    logic setup;
    logic clr_step;
    logic issue;
    logic modify;
    logic finish;
  } roc_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic rows_left;
  } roc_stat_t;

endpackage

>>> design/roc_if.sv
// Valid/ready channel interfaces for rectangle requests and hit results.
// Depends on roc_pkg for the field widths.
interface roc_in_if;
  import roc_pkg::*;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [POS_W-1:0] rect_x;
  logic [POS_W-1:0] rect_y;
  logic [EXT_W-1:0] rect_w;
  logic [EXT_W-1:0] rect_h;

  modport source (output valid, op, rect_x, rect_y, rect_w, rect_h, input ready);
  modport sink   (input valid, op, rect_x, rect_y, rect_w, rect_h, output ready);
endinterface

interface roc_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink   (input valid, hit, output ready);
endinterface

>>> design/rect_occupancy_bitmap_top.sv
// Rectangle occupancy bitmap: a GRID_ROWS x GRID_COLS grid of occupancy bits,
// one word per grid row. Each request tests, marks or clears the cells under
// a pixel rectangle (cell edges at coordinate / CELL_SIZE, clamped to the
// grid) and returns one hit beat; the unused opcode changes nothing and
// returns no hit. After reset the block zeroes the row store with
// in_ch.ready low. Each item then occupies the block through its divide and
// clamp stages, a read-modify-write of one row word per cycle for each grid
// row it covers, and its result stage. A finished result waits in its own
// register, so the next request is taken while out_ch is stalled.
module rect_occupancy_bitmap_top #(
  parameter int GRID_ROWS = roc_pkg::DEF_GRID_ROWS,
  parameter int GRID_COLS = roc_pkg::DEF_GRID_COLS,
  parameter int CELL_SIZE = roc_pkg::DEF_CELL_SIZE
) (
  input  logic       clk,
  input  logic       rst_n,
  roc_in_if.sink     in_ch,
  roc_out_if.source  out_ch
);
  import roc_pkg::*;

  roc_cmd_t  cmd;
  roc_stat_t stat;

  roc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  roc_dp #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS),
    .CELL_SIZE (CELL_SIZE)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .op     (in_ch.op),
    .rect_x (in_ch.rect_x),
    .rect_y (in_ch.rect_y),
    .rect_w (in_ch.rect_w),
    .rect_h (in_ch.rect_h),
    .stat   (stat),
    .hit    (out_ch.hit)
  );

endmodule

>>> design/roc_ctrl.sv
// Controller for the rectangle occupancy bitmap: clearing pass, per-item
// sequencing and the result beat. Depends on roc_pkg.
module roc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               out_ready,
  output logic               out_valid,
  input  roc_pkg::roc_stat_t stat,
  output roc_pkg::roc_cmd_t  cmd
);
  import roc_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_SETUP = 3'd3;
  localparam logic [2:0] ST_RUN   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       pend_r, pend_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        // read one row while the previous one is written back
        cmd.issue  = stat.rows_left;
        cmd.modify = pend_r;
        if (!stat.rows_left) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign pend_nxt      = cmd.issue;
  assign out_valid_nxt = cmd.finish ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> design/roc_dp.sv
// Datapath for the rectangle occupancy bitmap: cell-index divide and clamp,
// column mask, row store and hit accumulation. Depends on roc_pkg.
module roc_dp #(
  parameter int GRID_ROWS = roc_pkg::DEF_GRID_ROWS,
  parameter int GRID_COLS = roc_pkg::DEF_GRID_COLS,
  parameter int CELL_SIZE = roc_pkg::DEF_CELL_SIZE
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  roc_pkg::roc_cmd_t         cmd,
  input  logic [roc_pkg::OP_W-1:0]  op,
  input  logic [roc_pkg::POS_W-1:0] rect_x,
  input  logic [roc_pkg::POS_W-1:0] rect_y,
  input  logic [roc_pkg::EXT_W-1:0] rect_w,
  input  logic [roc_pkg::EXT_W-1:0] rect_h,
  output roc_pkg::roc_stat_t        stat,
  output logic                      hit
);
  import roc_pkg::*;

  localparam int AW    = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int CW    = $clog2(GRID_ROWS + 1);
  localparam int CCW   = $clog2(GRID_COLS + 1);
  localparam int PW    = SUM_W + RECIP_W;
  localparam int RECIP = ((1 << DIV_SH) + CELL_SIZE - 1) / CELL_SIZE;
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

  logic [GRID_COLS-1:0] mem [GRID_ROWS];

  logic [OP_W-1:0]      op_r;
  logic [SUM_W-1:0]     xs_r, xe_r, ys_r, ye_r;
  logic [SUM_W-1:0]     qxs_r, qxe_r, qys_r, qye_r;
  logic [PW-1:0]        pxs, pxe, pys, pye;
  logic [CCW-1:0]       c0, c1;
  logic [CW-1:0]        r0, r1;
  logic [GRID_COLS-1:0] mask, mask_r;
  logic [CW-1:0]        r1_r;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [AW-1:0]        wr_row_r;
  logic [GRID_COLS-1:0] rd_q_r;
  logic                 hit_acc_r, hit_r;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [GRID_COLS-1:0] wdata;

  // capture the request with both edges as pixel sums
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= op;
      xs_r <= SUM_W'(rect_x);
      xe_r <= SUM_W'(rect_x) + SUM_W'(rect_w);
      ys_r <= SUM_W'(rect_y);
      ye_r <= SUM_W'(rect_y) + SUM_W'(rect_h);
    end
  end

  // divide by the cell size as a multiply by its rounded-up reciprocal
  assign pxs = PW'(xs_r) * PW'(RECIP_C);
  assign pxe = PW'(xe_r) * PW'(RECIP_C);
  assign pys = PW'(ys_r) * PW'(RECIP_C);
  assign pye = PW'(ye_r) * PW'(RECIP_C);

  always_ff @(posedge clk) begin
    qxs_r <= pxs[DIV_SH +: SUM_W];
    qxe_r <= pxe[DIV_SH +: SUM_W];
    qys_r <= pys[DIV_SH +: SUM_W];
    qye_r <= pye[DIV_SH +: SUM_W];
  end

  // clamp to the grid and build the column mask
  always_comb begin
    c0 = (qxs_r > SUM_W'(GRID_COLS)) ? CCW'(GRID_COLS) : qxs_r[CCW-1:0];
    c1 = (qxe_r > SUM_W'(GRID_COLS)) ? CCW'(GRID_COLS) : qxe_r[CCW-1:0];
    r0 = (qys_r > SUM_W'(GRID_ROWS)) ? CW'(GRID_ROWS) : qys_r[CW-1:0];
    r1 = (qye_r > SUM_W'(GRID_ROWS)) ? CW'(GRID_ROWS) : qye_r[CW-1:0];
    for (int i = 0; i < GRID_COLS; i++) begin
      mask[i] = (CCW'(i) >= c0) && (CCW'(i) < c1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      mask_r <= mask;
      r1_r   <= r1;
    end
  end

  // row counter walks the clearing pass and then each item's rows
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.setup) begin
      cnt_nxt = r0;
    end else if (cmd.clr_step || cmd.issue) begin
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign stat.clr_last  = (cnt_r == CW'(GRID_ROWS - 1));
  assign stat.rows_left = (cnt_r < r1_r);

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_q_r   <= mem[cnt_r[AW-1:0]];
      wr_row_r <= cnt_r[AW-1:0];
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = cnt_r[AW-1:0];
    wdata = '0;
    if (cmd.clr_step) begin
      we = 1'b1;
    end else if (cmd.modify) begin
      waddr = wr_row_r;
      case (op_r)
        OP_MARK: begin
          we    = 1'b1;
          wdata = rd_q_r | mask_r;
        end
        OP_CLEAR: begin
          we    = 1'b1;
          wdata = rd_q_r & ~mask_r;
        end
        default: begin
          we    = 1'b0;
          wdata = rd_q_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      hit_acc_r <= 1'b0;
    end else if (cmd.modify && (op_r == OP_TEST) && (|(rd_q_r & mask_r))) begin
      hit_acc_r <= 1'b1;
    end
    if (cmd.finish) begin
      hit_r <= hit_acc_r;
    end
  end

  assign hit = hit_r;

endmodule

>>> design/roc_checker.sv
// Port-level checks for the rectangle occupancy bitmap, bound to the top.
// Depends on rect_occupancy_bitmap_top_assert.svh for the assertion macros.
`include "rect_occupancy_bitmap_top_assert.svh"

module roc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_hit
);

  // a stalled result beat stays up and unchanged
  `ROC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")
  `ROC_ASSERT_NEXT(a_hit_stable, out_valid && !out_ready, $stable(out_hit), "hit changed")
  // one item at a time: busy right after a request beat
  `ROC_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready, "ready after accept")
  // the clearing pass follows every reset
  `ROC_ASSERT_NEXT_ANY(a_clear_after_rst, !rst_n, !in_ready, "ready during clear")

endmodule

bind rect_occupancy_bitmap_top roc_checker u_roc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_hit   (out_ch.hit)
);

>>> sim/tb_rect_occupancy_bitmap_top.sv
`timescale 1ns / 1ps
// Self-checking bench for rect_occupancy_bitmap_top: drives rectangle requests,
// predicts the hit bit from a private occupancy grid and checks every result beat.
// Depends on roc_pkg and the roc_in_if / roc_out_if channel interfaces.
module tb_rect_occupancy_bitmap_top;
  import roc_pkg::*;

  localparam int GRID_ROWS   = DEF_GRID_ROWS;
  localparam int GRID_COLS   = DEF_GRID_COLS;
  localparam int CELL_SIZE   = DEF_CELL_SIZE;
  localparam int RANDOM_REQS = 700;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 2 * GRID_ROWS + 20;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [EXT_W-1:0] w;
    logic [EXT_W-1:0] h;
  } rect_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             drv_valid = 1'b0;
  logic [OP_W-1:0]  drv_op = '0;
  logic [POS_W-1:0] drv_x = '0;
  logic [POS_W-1:0] drv_y = '0;
  logic [EXT_W-1:0] drv_w = '0;
  logic [EXT_W-1:0] drv_h = '0;
  logic             rcv_ready = 1'b0;

  roc_in_if  in_ch ();
  roc_out_if out_ch ();

  assign in_ch.valid  = drv_valid;
  assign in_ch.op     = drv_op;
  assign in_ch.rect_x = drv_x;
  assign in_ch.rect_y = drv_y;
  assign in_ch.rect_w = drv_w;
  assign in_ch.rect_h = drv_h;
  assign out_ch.ready = rcv_ready;

  rect_occupancy_bitmap_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  rect_req_t pending_reqs[$];
  bit        hit_expect[$];
  logic [GRID_COLS-1:0] grid_rows [GRID_ROWS];

  int total_items = 0;
  int in_beats = 0;
  int hit_beats = 0;
  int mismatch_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int n_test = 0, n_mark = 0, n_clear = 0, n_unused = 0, n_hits = 0;

  initial begin
    for (int r = 0; r < GRID_ROWS; r++) grid_rows[r] = '0;
  end

  task automatic note_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Map the rectangle to grid cells, apply it to the grid, return the hit bit.
  function automatic bit apply_rect(input rect_req_t rq);
    int c0, c1, r0, r1;
    logic [GRID_COLS-1:0] span;
    bit found;
    c0 = int'(rq.x) / CELL_SIZE;
    c1 = (int'(rq.x) + int'(rq.w)) / CELL_SIZE;
    r0 = int'(rq.y) / CELL_SIZE;
    r1 = (int'(rq.y) + int'(rq.h)) / CELL_SIZE;
    if (c0 > GRID_COLS) c0 = GRID_COLS;
    if (c1 > GRID_COLS) c1 = GRID_COLS;
    if (r0 > GRID_ROWS) r0 = GRID_ROWS;
    if (r1 > GRID_ROWS) r1 = GRID_ROWS;
    span = '0;
    for (int c = c0; c < c1; c++) span[c] = 1'b1;
    found = 1'b0;
    for (int r = r0; r < r1; r++) begin
      case (rq.op)
        OP_TEST:  if ((grid_rows[r] & span) != '0) found = 1'b1;
        OP_MARK:  grid_rows[r] = grid_rows[r] | span;
        OP_CLEAR: grid_rows[r] = grid_rows[r] & ~span;
        default: ;
      endcase
    end
    case (rq.op)
      OP_TEST:  n_test++;
      OP_MARK:  n_mark++;
      OP_CLEAR: n_clear++;
      default:  n_unused++;
    endcase
    if (found) n_hits++;
    return found;
  endfunction

  function automatic int idle_pct(input int beats, input bit rx_side);
    int phase;
    phase = (total_items == 0) ? 0 : (beats * 3) / total_items;
    case (phase)
      0:       return rx_side ? 73 : 15;
      1:       return rx_side ? 15 : 73;
      default: return 0;
    endcase
  endfunction

  task automatic add_req(input logic [OP_W-1:0] op, input int x, input int y,
                         input int w, input int h);
    rect_req_t rq;
    rq.op = op;
    rq.x  = x[POS_W-1:0];
    rq.y  = y[POS_W-1:0];
    rq.w  = w[EXT_W-1:0];
    rq.h  = h[EXT_W-1:0];
    pending_reqs.push_back(rq);
  endtask

  function automatic int pick_extent();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) return $urandom_range(0, 64);
    if (sel < 95) return $urandom_range(0, 200);
    return $urandom_range(0, 512);
  endfunction

  // Request driver: the item on the bus is always the head of pending_reqs.
  always @(posedge clk) begin : req_driver
    rect_req_t nxt;
    bit taken;
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else begin
      taken = drv_valid && in_ch.ready;
      if (taken) begin
        hit_expect.push_back(apply_rect(pending_reqs.pop_front()));
        in_beats <= in_beats + 1;
      end
      if (!drv_valid || taken) begin
        if (pending_reqs.size() != 0 &&
            $urandom_range(0, 99) >= idle_pct(in_beats, 1'b0)) begin
          nxt = pending_reqs[0];
          drv_valid <= 1'b1;
          drv_op    <= nxt.op;
          drv_x     <= nxt.x;
          drv_y     <= nxt.y;
          drv_w     <= nxt.w;
          drv_h     <= nxt.h;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // Hold off the result channel once, late in the run, so the block backs up.
  always @(posedge clk) begin : result_hold
    if (rst_n) begin
      if (!hold_done && total_items != 0 && in_beats >= (total_items * 5) / 6) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  always @(posedge clk) begin : hit_monitor
    bit want;
    if (!rst_n) begin
      rcv_ready <= 1'b0;
    end else begin
      if (out_ch.valid && rcv_ready) begin
        hit_beats <= hit_beats + 1;
        if (hit_expect.size() == 0) begin
          note_mismatch($sformatf("result beat with no request pending, hit=%0b",
                                  out_ch.hit));
        end else begin
          want = hit_expect.pop_front();
          if (out_ch.hit !== want)
            note_mismatch($sformatf("result %0d: hit=%0b, predicted %0b",
                                    hit_beats, out_ch.hit, want));
        end
      end
      rcv_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= idle_pct(in_beats, 1'b1));
    end
  end

  initial begin : stimulus
    int sel;
    logic [OP_W-1:0] op;
    // Directed: empty grid, corner cell, clamping, empty spans, unused opcode.
    add_req(OP_TEST,    0,   0,   512, 512);
    add_req(OP_MARK,    0,   0,   0,   0);
    add_req(OP_MARK,    511, 511, 512, 512);
    add_req(OP_TEST,    504, 504, 8,   8);
    add_req(OP_TEST,    0,   0,   504, 504);
    add_req(OP_UNUSED,  0,   0,   512, 512);
    add_req(OP_TEST,    0,   0,   512, 512);
    add_req(OP_MARK,    0,   0,   512, 512);
    add_req(OP_TEST,    7,   7,   0,   0);
    add_req(OP_TEST,    7,   7,   1,   1);
    add_req(OP_CLEAR,   8,   8,   496, 496);
    add_req(OP_TEST,    8,   8,   496, 496);
    add_req(OP_TEST,    0,   0,   9,   9);
    add_req(OP_CLEAR,   300, 0,   0,   512);
    add_req(OP_CLEAR,   0,   0,   512, 512);
    add_req(OP_TEST,    0,   0,   512, 512);
    add_req(OP_MARK,    256, 0,   255, 1);
    add_req(OP_MARK,    100, 200, 3,   9);
    add_req(OP_MARK,    170, 85,  341, 426);
    add_req(OP_TEST,    0,   0,   512, 512);
    add_req(OP_UNUSED,  0,   0,   0,   0);
    add_req(OP_TEST,    511, 511, 511, 511);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 2) begin
        // wipe the grid now and then so tests keep missing as well as hitting
        add_req(OP_CLEAR, 0, 0, 512, 512);
      end else begin
        if (sel < 42)      op = OP_TEST;
        else if (sel < 70) op = OP_MARK;
        else if (sel < 95) op = OP_CLEAR;
        else               op = OP_UNUSED;
        add_req(op, $urandom_range(0, 511), $urandom_range(0, 511),
                pick_extent(), pick_extent());
      end
    end
    total_items = pending_reqs.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || hit_expect.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d requests: %0d tests (%0d hits), %0d marks, %0d clears, %0d unused",
             total_items, n_test, n_hits, n_mark, n_clear, n_unused);
    $display("Three idle mixes plus a %0d-cycle result stall; %0d result beats checked",
             HOLD_CYCLES, hit_beats);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("ERROR: timeout with %0d requests and %0d results outstanding",
             pending_reqs.size(), hit_expect.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
